/* sv/pafb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pafb_pkg;
    localparam int MaxSegments = 16;
    localparam int AddrWidth   = 16;
    localparam int IdxWidth    = $clog2(MaxSegments);
    localparam int CntWidth    = $clog2(MaxSegments + 1);
    localparam logic [15:0] DefaultTotal = 16'd640;
    localparam logic [15:0] IdLimit      = 16'hFFFF;

    localparam logic [2:0] StAlloc    = 3'd0;
    localparam logic [2:0] StNoFit    = 3'd1;
    localparam logic [2:0] StFreed    = 3'd2;
    localparam logic [2:0] StFreeFail = 3'd3;
    localparam logic [2:0] StFull     = 3'd4;

    localparam logic KindAlloc = 1'b0;
    localparam logic KindFree  = 1'b1;

    localparam logic RegTotalSize = 1'b0;
    localparam logic RegFitPolicy = 1'b1;

    typedef struct packed {
        logic [AddrWidth-1:0] seg_begin;
        logic [AddrWidth-1:0] seg_end;
        logic                 seg_free;
        logic [15:0]          owner;
    } t_entry;

    // one command broadcast to every cell
    typedef struct packed {
        logic                reset_table;
        logic [AddrWidth-1:0] total;
        logic                remove;     // shift entries above rm_idx down one
        logic [IdxWidth-1:0] rm_idx;
        logic                open;       // shift entries at/above op_idx up one
        logic [IdxWidth-1:0] op_idx;
        logic                wr;         // write wr_entry at wr_idx (after shift)
        logic [IdxWidth-1:0] wr_idx;
        t_entry              wr_entry;
        logic                wr2;
        logic [IdxWidth-1:0] wr2_idx;
        t_entry              wr2_entry;
        logic                rotate;     // scan: every cell passes its entry down
    } t_cmd;
endpackage
`default_nettype wire

/* sv/pafb_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One table entry; shifts with neighbors, rotates for scanning.
module pafb_cell (
    input  wire logic                          i_clk,
    input  wire logic [pafb_pkg::IdxWidth-1:0] i_idx,
    input  wire pafb_pkg::t_cmd                i_cmd,
    input  wire pafb_pkg::t_entry              i_below,
    input  wire pafb_pkg::t_entry              i_above,
    output pafb_pkg::t_entry                   o_entry
);
    pafb_pkg::t_entry r_e, n_e;

    // select next entry value
    always_comb begin
        n_e = r_e;
        if (i_cmd.reset_table) begin
            n_e = '0;
            if (i_idx == '0) begin
                n_e.seg_begin = pafb_pkg::AddrWidth'(1);
                n_e.seg_end   = i_cmd.total;
                n_e.seg_free  = 1'b1;
            end
        end else if (i_cmd.rotate) begin
            n_e = i_above;
        end else begin
            if (i_cmd.remove && i_idx >= i_cmd.rm_idx) n_e = i_above;
            if (i_cmd.open && i_idx > i_cmd.op_idx) n_e = i_below;
            if (i_cmd.wr && i_idx == i_cmd.wr_idx) n_e = i_cmd.wr_entry;
            if (i_cmd.wr2 && i_idx == i_cmd.wr2_idx) n_e = i_cmd.wr2_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_entry = r_e;
endmodule
`default_nettype wire

/* sv/partition_allocator_first_best_fit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Partition allocator: a chain of sixteen table cells holds the segments in
// address order. A request is accepted in the idle state, then scanned while
// the chain rotates once through cell 0, which the controller inspects. An
// update state follows, after which the result is valid. A free whose segment
// merges with both neighbors takes an extra merge state to drop the second
// entry; its result is already valid during that state. A new request is
// accepted only after the result has been taken, so a stall on the result
// channel holds off the next request. One request is handled at a time. When
// a configuration write and a request are both pending in the idle state, the
// configuration write goes first. Writing total_size resets every cell of the
// table together; the chain has no clearing pass.
module partition_allocator_first_best_fit_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_request_size,
    input  wire logic [15:0] i_job_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_given_id,
    output logic [15:0]      o_base_address,
    output logic [15:0]      o_length,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int N  = pafb_pkg::MaxSegments;
    localparam int IW = pafb_pkg::IdxWidth;
    localparam int CW = pafb_pkg::CntWidth;
    localparam int AW = pafb_pkg::AddrWidth;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_UPD = 5'b00100,
        S_MRG  = 5'b01000, S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    pafb_pkg::t_cmd  w_cmd;
    pafb_pkg::t_entry w_e [N];
    pafb_pkg::t_entry w_below [N];
    pafb_pkg::t_entry w_above [N];

    logic [15:0]   r_total;
    logic          r_policy;
    logic [CW-1:0] r_count;
    logic          r_kind;
    logic [15:0]   r_req, r_jid;
    logic [IW-1:0] r_pos;
    logic          r_found, r_jfound;
    logic [IW-1:0] r_pick, r_jidx;
    logic [15:0]   r_best, r_maxid;
    // snapshots of the job entry, its neighbors and the picked entry, captured during scan
    pafb_pkg::t_entry r_jent, r_prev, r_next, r_pent, r_last;
    logic          r_ovalid;
    logic [2:0]    r_status;
    logic [15:0]   r_gid, r_base, r_len;

    // build the chain
    for (genvar g = 0; g < N; g++) begin : g_cells
        assign w_below[g] = (g == 0) ? w_e[N-1] : w_e[(g+N-1)%N];
        assign w_above[g] = w_e[(g+1)%N];
        pafb_cell u_cell (
            .i_clk(i_clk), .i_idx(IW'(g)), .i_cmd(w_cmd),
            .i_below(w_below[g]), .i_above(w_above[g]), .o_entry(w_e[g])
        );
    end

    logic in_acc, cfg_acc;
    // let a pending configuration write go ahead of a request
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc  = i_valid && o_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // scan view of cell 0
    pafb_pkg::t_entry c0;
    logic          c0_valid;
    logic [16:0]   c0_size;
    assign c0 = w_e[0];
    assign c0_valid = ({1'b0, r_pos} < r_count);
    assign c0_size = (c0.seg_end < c0.seg_begin) ? 17'd0
                   : {1'b0, c0.seg_end} - {1'b0, c0.seg_begin} + 17'd1;

    // update decision values
    logic [15:0] nid;
    logic [15:0] pick_size;
    logic [15:0] ne;
    logic        prev_free, next_free;
    pafb_pkg::t_entry alloc_e, hole_e, merge_e;
    always_comb begin
        nid = r_maxid + 16'd1;
        pick_size = r_pent.seg_end - r_pent.seg_begin + 16'd1;
        ne = r_pent.seg_begin + r_req - 16'd1;
        prev_free = (r_jidx != '0) && r_prev.seg_free;
        next_free = ({1'b0, r_jidx} + CW'(1) < r_count) && r_next.seg_free;
        alloc_e = '{seg_begin: r_pent.seg_begin, seg_end: ne, seg_free: 1'b0, owner: nid};
        hole_e  = r_pent;
        hole_e.seg_begin = ne + 16'd1;
        merge_e = r_jent;
        merge_e.seg_free = 1'b1;
    end

    // controller
    always_comb begin
        n_state = r_state;
        w_cmd = '0;
        w_cmd.total = (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
        w_cmd.reset_table = !i_rst_n || (cfg_acc && i_cfg_index == pafb_pkg::RegTotalSize);
        if (!i_rst_n) w_cmd.total = pafb_pkg::DefaultTotal;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_SCAN;
            S_SCAN: begin
                w_cmd.rotate = 1'b1;
                if (r_pos == IW'(N-1)) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_OUT;
                if (r_kind == pafb_pkg::KindAlloc) begin
                    if (r_req != 16'd0 && r_found && r_maxid != pafb_pkg::IdLimit) begin
                        if ({1'b0, pick_size} == {1'b0, r_req}) begin
                            w_cmd.wr = 1'b1; w_cmd.wr_idx = r_pick;
                            w_cmd.wr_entry = alloc_e;
                            w_cmd.wr_entry.seg_end = r_pent.seg_end;
                        end else if (r_count < CW'(N)) begin
                            w_cmd.open = 1'b1; w_cmd.op_idx = r_pick;
                            w_cmd.wr = 1'b1; w_cmd.wr_idx = r_pick;
                            w_cmd.wr_entry = alloc_e;
                            w_cmd.wr2 = 1'b1; w_cmd.wr2_idx = r_pick + IW'(1);
                            w_cmd.wr2_entry = hole_e;
                        end
                    end
                end else if (r_jfound && !r_jent.seg_free) begin
                    if (r_jidx == '0 || (!prev_free && !next_free)) begin
                        w_cmd.wr = 1'b1; w_cmd.wr_idx = r_jidx;
                        w_cmd.wr_entry = merge_e;
                        if (r_jidx == '0 && next_free) begin
                            w_cmd.wr_entry.seg_end = r_next.seg_end;
                            w_cmd.remove = 1'b1; w_cmd.rm_idx = r_jidx + IW'(1);
                        end
                    end else if (prev_free && next_free) begin
                        // merge into prev: drop the job entry now, the next one after
                        w_cmd.remove = 1'b1; w_cmd.rm_idx = r_jidx;
                        w_cmd.wr = 1'b1; w_cmd.wr_idx = r_jidx - IW'(1);
                        w_cmd.wr_entry = r_prev;
                        w_cmd.wr_entry.seg_end = r_next.seg_end;
                        n_state = S_MRG;
                    end else if (prev_free) begin
                        w_cmd.remove = 1'b1; w_cmd.rm_idx = r_jidx;
                        w_cmd.wr = 1'b1; w_cmd.wr_idx = r_jidx - IW'(1);
                        w_cmd.wr_entry = r_prev;
                        w_cmd.wr_entry.seg_end = r_jent.seg_end;
                    end else begin
                        w_cmd.remove = 1'b1; w_cmd.rm_idx = r_jidx;
                        w_cmd.wr = 1'b1; w_cmd.wr_idx = r_jidx;
                        w_cmd.wr_entry = r_next;
                        w_cmd.wr_entry.seg_begin = r_jent.seg_begin;
                    end
                end
            end
            // drop the old next entry, which now sits in the job slot
            S_MRG: begin
                w_cmd.remove = 1'b1; w_cmd.rm_idx = r_jidx;
                n_state = S_OUT;
            end
            S_OUT: if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= pafb_pkg::DefaultTotal;
            r_policy <= 1'b0;
            r_count  <= CW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            // configuration writes
            if (cfg_acc) begin
                if (i_cfg_index == pafb_pkg::RegTotalSize) begin
                    r_total <= w_cmd.total;
                    r_count <= CW'(1);
                end else begin
                    r_policy <= i_cfg_data[0];
                end
            end
            // latch transaction and start scan
            if (in_acc) begin
                r_kind <= i_kind; r_req <= i_request_size; r_jid <= i_job_id;
                r_pos <= '0; r_found <= 1'b0; r_jfound <= 1'b0;
                r_best <= r_total; r_maxid <= '0;
                r_last <= w_e[N-1];
            end
            // examine cell 0 as the chain rotates
            if (r_state == S_SCAN) begin
                r_pos  <= r_pos + IW'(1);
                r_last <= c0;
                if (c0_valid) begin
                    if (c0.owner > r_maxid) r_maxid <= c0.owner;
                    if (c0.seg_free && c0_size >= {1'b0, r_req}) begin
                        if (!r_policy) begin
                            if (!r_found) begin
                                r_found <= 1'b1; r_pick <= r_pos; r_pent <= c0;
                            end
                        end else if (c0_size <= {1'b0, r_best}) begin
                            r_best <= c0_size[15:0];
                            r_found <= 1'b1; r_pick <= r_pos; r_pent <= c0;
                        end
                    end
                    if (!r_jfound && c0.owner == r_jid) begin
                        r_jfound <= 1'b1; r_jidx <= r_pos; r_jent <= c0; r_prev <= r_last;
                        r_next <= w_e[1];
                    end
                end
            end
            // produce result
            if (r_state == S_UPD) begin
                r_ovalid <= 1'b1;
                if (r_kind == pafb_pkg::KindAlloc && (r_req == 16'd0 || !r_found)) begin
                    r_status <= pafb_pkg::StNoFit;
                    r_gid <= '0; r_base <= '0; r_len <= '0;
                end else if (r_kind == pafb_pkg::KindAlloc &&
                             (r_maxid == pafb_pkg::IdLimit ||
                              (pick_size != r_req && r_count >= CW'(N)))) begin
                    r_status <= pafb_pkg::StFull;
                    r_gid <= '0; r_base <= '0; r_len <= '0;
                end else if (r_kind == pafb_pkg::KindAlloc) begin
                    r_status <= pafb_pkg::StAlloc;
                    r_gid <= nid; r_base <= r_pent.seg_begin; r_len <= r_req;
                    if (pick_size != r_req) r_count <= r_count + CW'(1);
                end else if (!r_jfound || r_jent.seg_free) begin
                    r_status <= pafb_pkg::StFreeFail;
                    r_gid <= '0; r_base <= '0; r_len <= '0;
                end else begin
                    r_status <= pafb_pkg::StFreed;
                    r_gid <= r_jid; r_base <= r_jent.seg_begin;
                    r_len <= (r_jent.seg_end < r_jent.seg_begin) ? 16'd0
                           : r_jent.seg_end - r_jent.seg_begin + 16'd1;
                    if (r_jidx == '0) begin
                        if (next_free) r_count <= r_count - CW'(1);
                    end else if (prev_free && next_free) begin
                        r_count <= r_count - CW'(2);
                    end else if (prev_free || next_free) begin
                        r_count <= r_count - CW'(1);
                    end
                end
            end
        end
    end

    // outputs
    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_given_id     = r_gid;
    assign o_base_address = r_base;
    assign o_length       = r_len;

    // the segment count always stays between one and MaxSegments
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N) && r_count != '0) else $error("segment count out of range");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |-> r_state == S_IDLE) else $error("config while busy");
endmodule
`default_nettype wire

/* tb/sv/partition_allocator_first_best_fit_top_tb.sv */
`timescale 1ns / 1ps
module partition_allocator_first_best_fit_top_tb;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] given_id;
        logic [15:0] base_address;
        logic [15:0] length;
    } t_result;

    // Allocator mirror plus queue of pending responses
    class alloc_scoreboard;
        logic [15:0] seg_lo[pafb_pkg::MaxSegments];
        logic [15:0] seg_hi[pafb_pkg::MaxSegments];
        bit          seg_free[pafb_pkg::MaxSegments];
        logic [15:0] seg_owner[pafb_pkg::MaxSegments];
        int          seg_count;
        logic [15:0] total;
        bit          best_fit;
        t_result     pending[$];
        int          errors;

        function void init_table();
            for (int k = 0; k < pafb_pkg::MaxSegments; k++) begin
                seg_lo[k] = 0; seg_hi[k] = 0; seg_free[k] = 0; seg_owner[k] = 0;
            end
            seg_lo[0] = 1;
            seg_hi[0] = total;
            seg_free[0] = 1;
            seg_count = 1;
        endfunction

        function void write_reg(logic idx, logic [15:0] data);
            if (idx == pafb_pkg::RegTotalSize) begin
                total = (data == 0) ? 16'd1 : data;
                init_table();
            end else begin
                best_fit = data[0];
            end
        endfunction

        function void reset_state();
            total = pafb_pkg::DefaultTotal;
            best_fit = 0;
            init_table();
        endfunction

        function int span(int i);
            if (seg_hi[i] < seg_lo[i]) return 0;
            return int'(seg_hi[i]) - int'(seg_lo[i]) + 1;
        endfunction

        function void drop_entry(int at);
            for (int k = at; k + 1 < seg_count; k++) begin
                seg_lo[k] = seg_lo[k+1]; seg_hi[k] = seg_hi[k+1];
                seg_free[k] = seg_free[k+1]; seg_owner[k] = seg_owner[k+1];
            end
            seg_count--;
        endfunction

        // Predict the response for one accepted request
        function void note_request(logic kind, logic [15:0] req, logic [15:0] jid);
            t_result r;
            int pick, best, maxid, sz, i;
            bit found, pf, nf;
            r = '{pafb_pkg::StNoFit, 0, 0, 0};
            if (kind == pafb_pkg::KindAlloc) begin
                found = 0; pick = 0; best = total; maxid = 0;
                if (req != 0) begin
                    for (i = 0; i < seg_count; i++) begin
                        sz = span(i);
                        if (!seg_free[i] || sz < req) continue;
                        if (!best_fit) begin
                            pick = i; found = 1; break;
                        end
                        if (sz <= best) begin
                            best = sz; pick = i; found = 1;
                        end
                    end
                end
                if (found) begin
                    for (i = 0; i < seg_count; i++)
                        if (seg_owner[i] > maxid) maxid = seg_owner[i];
                    if (maxid >= pafb_pkg::IdLimit) begin
                        r.status = pafb_pkg::StFull;
                    end else if (span(pick) == req) begin
                        seg_free[pick] = 0;
                        seg_owner[pick] = 16'(maxid + 1);
                        r = '{pafb_pkg::StAlloc, 16'(maxid + 1), seg_lo[pick], req};
                    end else if (seg_count >= pafb_pkg::MaxSegments) begin
                        r.status = pafb_pkg::StFull;
                    end else begin
                        for (int k = seg_count; k > pick; k--) begin
                            seg_lo[k] = seg_lo[k-1]; seg_hi[k] = seg_hi[k-1];
                            seg_free[k] = seg_free[k-1]; seg_owner[k] = seg_owner[k-1];
                        end
                        seg_count++;
                        r = '{pafb_pkg::StAlloc, 16'(maxid + 1), seg_lo[pick], req};
                        seg_hi[pick] = seg_lo[pick] + req - 1;
                        seg_free[pick] = 0;
                        seg_owner[pick] = 16'(maxid + 1);
                        seg_lo[pick+1] = seg_hi[pick] + 1;
                    end
                end
            end else begin
                found = 0;
                for (i = 0; i < seg_count; i++)
                    if (seg_owner[i] == jid) begin
                        found = 1; break;
                    end
                if (!found || seg_free[i]) begin
                    r.status = pafb_pkg::StFreeFail;
                end else begin
                    r = '{pafb_pkg::StFreed, jid, seg_lo[i], 16'(span(i))};
                    pf = (i > 0) && seg_free[i-1];
                    nf = (i + 1 < seg_count) && seg_free[i+1];
                    if (i == 0 || (!pf && !nf)) begin
                        seg_free[i] = 1;
                        if (i == 0 && nf) begin
                            seg_hi[0] = seg_hi[1];
                            drop_entry(1);
                        end
                    end else if (pf && nf) begin
                        seg_hi[i-1] = seg_hi[i+1];
                        drop_entry(i + 1);
                        drop_entry(i);
                    end else if (pf) begin
                        seg_hi[i-1] = seg_hi[i];
                        drop_entry(i);
                    end else begin
                        seg_lo[i+1] = seg_lo[i];
                        drop_entry(i);
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_result act);
            t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response status=%0d", $time, act.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (act.status !== exp.status) begin
                $display("%0t: status exp %0d act %0d", $time, exp.status, act.status);
                errors++;
            end
            if (act.given_id !== exp.given_id) begin
                $display("%0t: given_id exp %0d act %0d", $time, exp.given_id, act.given_id);
                errors++;
            end
            if (act.base_address !== exp.base_address) begin
                $display("%0t: base_address exp %0d act %0d", $time,
                         exp.base_address, act.base_address);
                errors++;
            end
            if (act.length !== exp.length) begin
                $display("%0t: length exp %0d act %0d", $time, exp.length, act.length);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_kind = 0;
    logic [15:0] i_request_size = 0;
    logic [15:0] i_job_id = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_status;
    logic [15:0] o_given_id;
    logic [15:0] o_base_address;
    logic [15:0] o_length;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;

    alloc_scoreboard sb;
    bit              quiet_phase = 0;
    int              stall_left = 0;

    partition_allocator_first_best_fit_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Send one request, outside the quiet phase sometimes with a random idle burst ahead of it
    task automatic send_request(logic kind, logic [15:0] req, logic [15:0] jid);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        i_valid <= 1;
        i_kind <= kind;
        i_request_size <= req;
        i_job_id <= jid;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(kind, req, jid);
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: small allocations and frees of live ids
    task automatic random_requests(int n);
        logic [15:0] jid, req;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0: req = 16'($urandom);
                    1: req = 0;
                    default: req = 16'($urandom_range(1, sb.total / 4 + 1));
                endcase
                send_request(pafb_pkg::KindAlloc, req, 16'($urandom));
            end else begin
                jid = (sb.seg_count > 0 && $urandom_range(0, 7) != 0)
                    ? sb.seg_owner[$urandom_range(0, sb.seg_count - 1)] : 16'($urandom);
                send_request(pafb_pkg::KindFree, 16'($urandom), jid);
            end
        end
    endtask

    // Accept responses, with stalls in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result('{o_status, o_given_id, o_base_address, o_length});
            if (quiet_phase) begin
                i_ready <= 1;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_ready <= (stall_left == 0);
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 11);
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    initial begin
        sb = new();
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, exact fit, merges, failures
        send_request(pafb_pkg::KindAlloc, 0, 0);
        send_request(pafb_pkg::KindAlloc, 16'hFFFF, 0);
        send_request(pafb_pkg::KindFree, 0, 0);
        send_request(pafb_pkg::KindFree, 0, 16'hFFFF);
        send_request(pafb_pkg::KindAlloc, 100, 0);
        send_request(pafb_pkg::KindAlloc, 200, 0);
        send_request(pafb_pkg::KindAlloc, 340, 0);
        send_request(pafb_pkg::KindAlloc, 1, 0);
        send_request(pafb_pkg::KindFree, 0, 2);
        send_request(pafb_pkg::KindFree, 0, 2);
        send_request(pafb_pkg::KindFree, 0, 1);
        send_request(pafb_pkg::KindFree, 0, 3);
        drain();
        write_cfg(pafb_pkg::RegFitPolicy, 1);
        write_cfg(pafb_pkg::RegTotalSize, 0);
        send_request(pafb_pkg::KindAlloc, 1, 0);
        send_request(pafb_pkg::KindAlloc, 1, 0);
        send_request(pafb_pkg::KindFree, 0, 1);
        drain();
        write_cfg(pafb_pkg::RegTotalSize, 16'hFFFF);
        for (int k = 0; k < 17; k++)
            send_request(pafb_pkg::KindAlloc, 16'($urandom_range(1, 9)), 0);
        drain();

        // Random phases across settings
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(pafb_pkg::RegFitPolicy, 16'(ph[0]));
            write_cfg(pafb_pkg::RegTotalSize, (ph == 2) ? 16'hFFFF : (ph == 4) ? 16'd1
                                    : 16'($urandom_range(16, 2000)));
            if (ph == 5) quiet_phase = 1;
            random_requests(280);
            drain();
        end
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
